### design/lld_pkg.sv
package lld_pkg;

  localparam int CoordW     = 16;
  localparam int SepW       = 18;
  localparam int SearchBits = 19;
  localparam int DiffW      = CoordW + 1;
  localparam int ProdW      = 2 * CoordW;
  localparam int CrossW     = ProdW + 1;
  localparam int CrossMagW  = ProdW;
  localparam int NsqW       = 2 * CrossMagW;
  localparam int SqW        = NsqW + 2;
  localparam int DotW       = DiffW + CrossW;
  localparam int DotSumW    = DotW + 2;
  localparam int MagW       = 50;
  localparam int HalfW      = MagW / 2;
  localparam int PartW      = 2 * HalfW;
  localparam int WideW      = 110;

  localparam logic [SepW-1:0] SepMax = '1;

endpackage

### design/lld_if.sv
interface lld_in_if import lld_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] a_point_x;
  logic signed [CoordW-1:0] a_point_y;
  logic signed [CoordW-1:0] a_point_z;
  logic signed [CoordW-1:0] a_dir_x;
  logic signed [CoordW-1:0] a_dir_y;
  logic signed [CoordW-1:0] a_dir_z;
  logic signed [CoordW-1:0] b_point_x;
  logic signed [CoordW-1:0] b_point_y;
  logic signed [CoordW-1:0] b_point_z;
  logic signed [CoordW-1:0] b_dir_x;
  logic signed [CoordW-1:0] b_dir_y;
  logic signed [CoordW-1:0] b_dir_z;

  modport source (output valid, a_point_x, a_point_y, a_point_z, a_dir_x, a_dir_y, a_dir_z,
                  b_point_x, b_point_y, b_point_z, b_dir_x, b_dir_y, b_dir_z,
                  input ready);
  modport sink (input valid, a_point_x, a_point_y, a_point_z, a_dir_x, a_dir_y, a_dir_z,
                b_point_x, b_point_y, b_point_z, b_dir_x, b_dir_y, b_dir_z,
                output ready);
endinterface

interface lld_out_if import lld_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SepW-1:0] separation;
  logic            lines_parallel;
  logic            saturated;

  modport source (output valid, separation, lines_parallel, saturated, input ready);
  modport sink (input valid, separation, lines_parallel, saturated, output ready);
endinterface

### design/line_line_distance.sv
// Channel  Dir  Payload
// in_i     in   two lines: a/b point and direction x/y/z, signed Q8.8
// out_o    out  separation (Q10.8), lines_parallel, saturated
//
// One transaction per cycle while the output is taken; the path from input to
// the output register is 6 arithmetic stages plus 19 root-search stages (one
// result bit each) plus the output register.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline holds while the output register is full and not taken.
module line_line_distance import lld_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lld_in_if.sink    in_i,
  lld_out_if.source out_o
);

  logic adv;
  logic vo_q;

  // Advance every stage together whenever the output slot frees up.
  assign adv        = !vo_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: cross-product terms and point difference.
  logic signed [ProdW-1:0] p_q [6];
  logic signed [DiffW-1:0] diff1_q [3];
  logic signed [CoordW-1:0] da [3], db [3], pa [3], pb [3];
  logic v1_q;

  assign da = '{in_i.a_dir_x, in_i.a_dir_y, in_i.a_dir_z};
  assign db = '{in_i.b_dir_x, in_i.b_dir_y, in_i.b_dir_z};
  assign pa = '{in_i.a_point_x, in_i.a_point_y, in_i.a_point_z};
  assign pb = '{in_i.b_point_x, in_i.b_point_y, in_i.b_point_z};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= da[1] * db[2];
      p_q[1] <= da[2] * db[1];
      p_q[2] <= da[2] * db[0];
      p_q[3] <= da[0] * db[2];
      p_q[4] <= da[0] * db[1];
      p_q[5] <= da[1] * db[0];
      for (int i = 0; i < 3; i++) begin
        diff1_q[i] <= $signed({pa[i][CoordW-1], pa[i]}) - $signed({pb[i][CoordW-1], pb[i]});
      end
    end
  end

  // Stage 2: normal vector n = da x db.
  logic signed [CrossW-1:0] n_q [3];
  logic signed [DiffW-1:0]  diff2_q [3];
  logic v2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= $signed({p_q[2*i][ProdW-1], p_q[2*i]})
                - $signed({p_q[2*i+1][ProdW-1], p_q[2*i+1]});
        diff2_q[i] <= diff1_q[i];
      end
    end
  end

  // Stage 3: squared components of n and the terms of (pa-pb).n.
  logic [NsqW-1:0]        nsq_q [3];
  logic signed [DotW-1:0] dp_q [3];
  logic [CrossMagW-1:0]   nmag [3];
  logic v3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = CrossMagW'(n_q[i][CrossW-1] ? -n_q[i] : n_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nsq_q[i] <= nmag[i] * nmag[i];
        dp_q[i]  <= diff2_q[i] * n_q[i];
      end
    end
  end

  // Stage 4: |n|^2 and |(pa-pb).n|.
  logic [SqW-1:0]            sq4_q;
  logic [MagW-1:0]           mag4_q;
  logic                      par4_q;
  logic signed [DotSumW-1:0] dot_sum;
  logic [SqW-1:0]            sq_sum;
  logic v4_q;

  always_comb begin
    dot_sum = DotSumW'(dp_q[0]) + DotSumW'(dp_q[1]) + DotSumW'(dp_q[2]);
    sq_sum  = SqW'(nsq_q[0]) + SqW'(nsq_q[1]) + SqW'(nsq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq4_q  <= sq_sum;
      par4_q <= (sq_sum == '0);
      mag4_q <= MagW'(dot_sum[DotSumW-1] ? -dot_sum : dot_sum);
    end
  end

  // Stage 5: split square of the magnitude into half-width products.
  logic [PartW-1:0] hh_q, hl_q, ll_q;
  logic [SqW-1:0]   sq5_q;
  logic             par5_q;
  logic v5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hh_q   <= mag4_q[MagW-1:HalfW] * mag4_q[MagW-1:HalfW];
      hl_q   <= mag4_q[MagW-1:HalfW] * mag4_q[HalfW-1:0];
      ll_q   <= mag4_q[HalfW-1:0] * mag4_q[HalfW-1:0];
      sq5_q  <= sq4_q;
      par5_q <= par4_q;
    end
  end

  // Stage 6: N = (2|dot|)^2, seed remainder N - sq and slope -sq for r = 0.
  logic signed [WideW-1:0] rem_q [SearchBits+1];
  logic signed [WideW-1:0] slope_q [SearchBits+1];
  logic [SqW-1:0]          sqs_q [SearchBits+1];
  logic [SearchBits-1:0]   r_q [SearchBits+1];
  logic                    par_q [SearchBits+1];
  logic                    v_q [SearchBits+1];
  logic [WideW-1:0]        num_sq;
  logic signed [WideW-1:0] sq5_w;

  always_comb begin
    num_sq = ((WideW'(hh_q) << (2 * HalfW)) + (WideW'(hl_q) << (HalfW + 1))
             + WideW'(ll_q)) << 2;
    sq5_w  = $signed(WideW'(sq5_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]   <= $signed(num_sq) - sq5_w;
      slope_q[0] <= -sq5_w;
      sqs_q[0]   <= sq5_q;
      r_q[0]     <= '0;
      par_q[0]   <= par5_q;
    end
  end

  // Root search: test one result bit per stage, MSB first. With P = (2r-1)^2 sq
  // and slope = (2r-1) sq, setting bit b adds 2^(b+2) (slope + 2^b sq) to P.
  for (genvar j = 0; j < SearchBits; j++) begin : g_search
    localparam int B = SearchBits - 1 - j;
    logic signed [WideW-1:0] sqw, step, rem_c;
    logic                    take;

    always_comb begin
      sqw   = $signed(WideW'(sqs_q[j]));
      step  = slope_q[j] + (sqw <<< B);
      rem_c = rem_q[j] - (step <<< (B + 2));
      take  = !rem_c[WideW-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqs_q[j+1] <= sqs_q[j];
        par_q[j+1] <= par_q[j];
        if (take) begin
          rem_q[j+1]   <= rem_c;
          slope_q[j+1] <= step + (sqw <<< B);
          r_q[j+1]     <= r_q[j] | (SearchBits'(1) << B);
        end else begin
          rem_q[j+1]   <= rem_q[j];
          slope_q[j+1] <= slope_q[j];
          r_q[j+1]     <= r_q[j];
        end
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int k = 0; k <= SearchBits; k++) begin
        v_q[k] <= 1'b0;
      end
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v_q[0] <= v5_q;
      for (int k = 0; k < SearchBits; k++) begin
        v_q[k+1] <= v_q[k];
      end
      vo_q <= v_q[SearchBits];
    end
  end

  // Output register: clamp to the Q10.8 range, force zero for parallel lines.
  logic [SepW-1:0] sep_q;
  logic            parl_q, sat_q;
  logic [SearchBits-1:0] r_last;

  assign r_last = r_q[SearchBits];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      parl_q <= par_q[SearchBits];
      if (par_q[SearchBits]) begin
        sep_q <= '0;
        sat_q <= 1'b0;
      end else if (r_last > SearchBits'(SepMax)) begin
        sep_q <= SepMax;
        sat_q <= 1'b1;
      end else begin
        sep_q <= r_last[SepW-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = vo_q;
  assign out_o.separation     = sep_q;
  assign out_o.lines_parallel = parl_q;
  assign out_o.saturated      = sat_q;

`ifndef SYNTHESIS
  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.lines_parallel |-> out_o.separation == '0 && !out_o.saturated)
    else $error("parallel result with nonzero separation");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |-> out_o.separation == SepMax)
    else $error("saturated result not clamped");

  a_ready_tracks_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("input ready does not follow output slot");
`endif

endmodule

### sim/lld_tb_checker.sv
module lld_tb_checker import lld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lld_in_if.sink    mon_in,
  lld_out_if.sink   mon_out,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_seen_o,
  output int        parallel_seen_o
);

  typedef struct packed {
    logic [SepW-1:0] separation;
    logic            lines_parallel;
    logic            saturated;
  } dist_result_t;

  dist_result_t dist_fifo[$];

  // Exact distance |(pa-pb).n| / |n| with n = da x db, rounded to nearest.
  function automatic dist_result_t predict_distance(
      input logic signed [CoordW-1:0] pa [3], input logic signed [CoordW-1:0] da [3],
      input logic signed [CoordW-1:0] pb [3], input logic signed [CoordW-1:0] db [3]);
    logic signed [127:0] dv [3];
    logic signed [127:0] nv [3];
    logic signed [127:0] dotn;
    logic [127:0] nsq, twice, lhs, rhs, cand, k;
    logic [SearchBits:0] root;
    dist_result_t res;
    for (int i = 0; i < 3; i++) dv[i] = 128'(signed'(pa[i])) - 128'(signed'(pb[i]));
    nv[0] = 128'(signed'(da[1])) * db[2] - 128'(signed'(da[2])) * db[1];
    nv[1] = 128'(signed'(da[2])) * db[0] - 128'(signed'(da[0])) * db[2];
    nv[2] = 128'(signed'(da[0])) * db[1] - 128'(signed'(da[1])) * db[0];
    nsq = nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2];
    res = '0;
    if (nsq == 0) begin
      res.lines_parallel = 1'b1;
      return res;
    end
    dotn = dv[0] * nv[0] + dv[1] * nv[1] + dv[2] * nv[2];
    twice = (dotn < 0) ? -dotn : dotn;
    twice = twice << 1;
    rhs = twice * twice;
    root = '0;
    for (int b = SearchBits - 1; b >= 0; b--) begin
      cand = 128'(root) | (128'd1 << b);
      k = 2 * cand - 1;
      lhs = k * k * nsq;
      if (lhs <= rhs) root = cand[SearchBits:0];
    end
    if (root > SepMax) begin
      res.separation = SepMax;
      res.saturated  = 1'b1;
    end else begin
      res.separation = root[SepW-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [CoordW-1:0] pa [3], da [3], pb [3], db [3];
    dist_result_t got, want;
    if (!rst_ni) begin
      dist_fifo.delete();
      fail_count_o    <= 0;
      results_seen_o  <= 0;
      parallel_seen_o <= 0;
    end else begin
      if (mon_in.valid && mon_in.ready) begin
        pa = '{mon_in.a_point_x, mon_in.a_point_y, mon_in.a_point_z};
        da = '{mon_in.a_dir_x, mon_in.a_dir_y, mon_in.a_dir_z};
        pb = '{mon_in.b_point_x, mon_in.b_point_y, mon_in.b_point_z};
        db = '{mon_in.b_dir_x, mon_in.b_dir_y, mon_in.b_dir_z};
        dist_fifo.push_back(predict_distance(pa, da, pb, db));
      end
      if (mon_out.valid && mon_out.ready) begin
        got = '{mon_out.separation, mon_out.lines_parallel, mon_out.saturated};
        results_seen_o  <= results_seen_o + 1;
        parallel_seen_o <= parallel_seen_o + got.lines_parallel;
        if (dist_fifo.size() == 0) begin
          $display("%0t: unexpected result sep=%0d par=%0b sat=%0b", $time,
                   got.separation, got.lines_parallel, got.saturated);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = dist_fifo.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected sep=%0d par=%0b sat=%0b, got sep=%0d par=%0b sat=%0b",
                     $time, want.separation, want.lines_parallel, want.saturated,
                     got.separation, got.lines_parallel, got.saturated);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = dist_fifo.size();

endmodule

### sim/tb_line_line_distance.sv
module tb_line_line_distance;
  import lld_pkg::*;

  localparam int Latency    = 26;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, results_seen, parallel_seen;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   items_sent = 0;

  lld_in_if  in_ch ();
  lld_out_if out_ch ();

  line_line_distance u_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  lld_tb_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .mon_in(in_ch), .mon_out(out_ch),
    .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen), .parallel_seen_o(parallel_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_line_line_distance: done, errors");
      $finish;
    end
  end

  // Receiver: stall at the rate of the current phase, re-drawn each falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  logic signed [CoordW-1:0] lane [12];

  // Drive one transaction and hold it until accepted.
  task automatic send_pair();
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.a_point_x, in_ch.a_point_y, in_ch.a_point_z} <= {lane[0], lane[1], lane[2]};
    {in_ch.a_dir_x, in_ch.a_dir_y, in_ch.a_dir_z}       <= {lane[3], lane[4], lane[5]};
    {in_ch.b_point_x, in_ch.b_point_y, in_ch.b_point_z} <= {lane[6], lane[7], lane[8]};
    {in_ch.b_dir_x, in_ch.b_dir_y, in_ch.b_dir_z}       <= {lane[9], lane[10], lane[11]};
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic signed [CoordW-1:0] pick_coord();
    case ($urandom_range(5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return CoordW'($urandom_range(0, 511)) - 16'sd256;
      default: return CoordW'($urandom);
    endcase
  endfunction

  // Random pair; a quarter of them have direction b as a multiple of direction a.
  task automatic random_pair();
    int m;
    for (int i = 0; i < 12; i++) lane[i] = pick_coord();
    if ($urandom_range(3) == 0) begin
      m = $urandom_range(0, 6) - 3;
      for (int i = 0; i < 3; i++) begin
        lane[3 + i] = CoordW'($urandom_range(0, 8191)) - 16'sd4096;
        lane[9 + i] = CoordW'(lane[3 + i] * m);
      end
    end
    send_pair();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 12; i++) lane[i] = '0;
    {in_ch.a_point_x, in_ch.a_point_y, in_ch.a_point_z} <= '0;
    {in_ch.a_dir_x, in_ch.a_dir_y, in_ch.a_dir_z}       <= '0;
    {in_ch.b_point_x, in_ch.b_point_y, in_ch.b_point_z} <= '0;
    {in_ch.b_dir_x, in_ch.b_dir_y, in_ch.b_dir_z}       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero directions, parallel, orthogonal axes, extremes.
    lane = '{default: 16'sh0000};
    send_pair();
    lane = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256};
    send_pair();
    lane = '{0, 0, 0, 256, 0, 0, 0, 0, 0, 512, 0, 0};
    send_pair();
    lane = '{0, 0, 0, 256, 0, 0, 0, 0, 0, -256, 0, 0};
    send_pair();
    lane = '{0, 0, 0, 256, 0, 0, 0, 0, 0, 0, 0, 0};
    send_pair();
    lane = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0,
             16'sh8000, 16'sh8000, 16'sh8000, 0, 16'sh7FFF, 0};
    send_pair();
    lane = '{16'sh8000, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
             16'sh7FFF, 0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
    send_pair();
    lane = '{default: 16'sh8000};
    send_pair();
    lane = '{default: 16'sh7FFF};
    send_pair();
    lane = '{default: 16'shFFFF};
    send_pair();
    lane = '{1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1};
    send_pair();
    lane = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
             16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555};
    send_pair();

    // Hold the sender until the pipeline has drained.
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    // Random phases: free run, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 86 : (phase == 3) ? 16 : 0;
      sink_stall_pct = (phase == 2) ? 86 : (phase == 3) ? 16 : 0;
      repeat (360) random_pair();
    end
    in_ch.valid <= 1'b0;
    sink_stall_pct = 0;

    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);

    $display("Sent %0d line pairs, checked %0d distances (%0d parallel) over four phases.",
             items_sent, results_seen, parallel_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_line_line_distance: done, clean");
    end else begin
      $display("tb_line_line_distance: done, errors");
    end
    $finish;
  end

endmodule
